// ===== src/sfp_pkg.sv =====
package sfp_pkg;

    // framing symbols
    localparam logic [7:0] SYM_START = 8'h24;
    localparam logic [7:0] SYM_LF    = 8'h0A;
    localparam logic [7:0] SYM_CR    = 8'h0D;

    // message kinds
    localparam logic [7:0] KIND_DATA  = 8'd1;
    localparam logic [7:0] KIND_DEBUG = 8'd3;

    // data kinds
    localparam logic [7:0] DK_ACCEL = 8'd0;
    localparam logic [7:0] DK_GYRO  = 8'd1;
    localparam logic [7:0] DK_ROT   = 8'd5;

    // request codes
    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // store targets
    localparam logic [1:0] TGT_NONE  = 2'd0;
    localparam logic [1:0] TGT_LINE  = 2'd1;
    localparam logic [1:0] TGT_DATA  = 2'd2;

    // completed record codes
    localparam logic [1:0] REC_NONE  = 2'd0;
    localparam logic [1:0] REC_ACCEL = 2'd1;
    localparam logic [1:0] REC_GYRO  = 2'd2;
    localparam logic [1:0] REC_ROT   = 2'd3;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } sfp_req_t;

    typedef struct packed {
        logic [1:0] write_target;
        logic [7:0] write_index;
        logic [7:0] write_byte;
        logic [1:0] record_done;
        logic       line_done;
    } sfp_res_t;

endpackage

// ===== src/sfp_if.sv =====
interface sfp_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface sfp_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] write_target;
    logic [7:0] write_index;
    logic [7:0] write_byte;
    logic [1:0] record_done;
    logic       line_done;

    modport source (output valid, output write_target, output write_index,
                    output write_byte, output record_done, output line_done,
                    input ready);
    modport sink   (input valid, input write_target, input write_index,
                    input write_byte, input record_done, input line_done,
                    output ready);
endinterface

// ===== src/sensor_frame_parser_top.sv =====
// sensor frame parser: deframes a received serial byte stream into debug
// text line writes and data record writes
//
// req_ch carries one request per transfer: a received byte (req_type 0)
// or a release of the held debug line (req_type 1)
// res_ch carries exactly one result per request, in order: the store to
// write (none, debug line, data record), index and byte, plus record_done
// and line_done flags
//
// a request passes through the input register and then the result
// register, which drives res_ch; throughput is one request per cycle
// while the receiver keeps res_ch.ready high, set by the single frame
// state update in the deframer
//
// reset clears frame position, message and data kind, line length and the
// line hold flag; both stage registers come up empty
// when the receiver stalls, the result register holds its transfer, the
// input register takes one more request if empty, then req_ch.ready drops
module sensor_frame_parser_top
    import sfp_pkg::*;
#(
    parameter int RECORD_BYTES = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    sfp_req_if.sink   req_ch,
    sfp_res_if.source res_ch
);

    logic     item_valid;
    logic     can_load;
    logic     advance;
    sfp_req_t item;
    sfp_res_t result;

    // a request moves from the input register into the result register
    // and updates the frame state in the same edge
    assign advance = item_valid && can_load;

    sfp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_ch     (req_ch),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sfp_deframer #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_deframer (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    sfp_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_ch   (res_ch),
        .load     (advance),
        .result   (result),
        .can_load (can_load)
    );

endmodule

// ===== src/sfp_in_stage.sv =====
module sfp_in_stage
    import sfp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    sfp_req_if.sink  req_ch,
    input  logic     advance,
    output logic     item_valid,
    output sfp_req_t item
);

    logic     valid_reg;
    logic     valid_next;
    sfp_req_t item_reg;

    // slot frees up when the held item moves on
    assign req_ch.ready = !valid_reg || advance;
    assign valid_next   = req_ch.valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req_ch.ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ch.ready && req_ch.valid)
        begin
            item_reg.req_type <= req_ch.req_type;
            item_reg.rx_byte  <= req_ch.rx_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== src/sfp_deframer.sv =====
module sfp_deframer
    import sfp_pkg::*;
#(
    parameter int RECORD_BYTES = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  sfp_req_t item,
    output sfp_res_t result
);

    localparam logic [7:0] LINE_LIMIT = 8'(RECORD_BYTES - 2);
    localparam logic [7:0] REC_LIMIT  = 8'(RECORD_BYTES);
    localparam logic [7:0] LAST_POS   = 8'(RECORD_BYTES - 1);

    logic [7:0] frame_pos_reg;
    logic [7:0] frame_pos_next;
    logic [7:0] message_kind_reg;
    logic [7:0] message_kind_next;
    logic [7:0] data_kind_reg;
    logic [7:0] data_kind_next;
    logic [7:0] line_len_reg;
    logic [7:0] line_len_next;
    logic       line_held_reg;
    logic       line_held_next;
    logic       kind_known;

    assign kind_known = (data_kind_reg == DK_ACCEL) || (data_kind_reg == DK_GYRO)
                     || (data_kind_reg == DK_ROT);

    always_comb
    begin
        result            = '0;
        frame_pos_next    = frame_pos_reg;
        message_kind_next = message_kind_reg;
        data_kind_next    = data_kind_reg;
        line_len_next     = line_len_reg;
        line_held_next    = line_held_reg;

        if (item.req_type == REQ_RELEASE)
        begin
            line_held_next = 1'b0;
        end
        else
        begin
            frame_pos_next = frame_pos_reg + 8'd1;
            if (item.rx_byte == SYM_START)
            begin
                frame_pos_next = 8'd1;
            end
            else if (frame_pos_reg == 8'd1)
            begin
                message_kind_next = item.rx_byte;
            end
            else if (message_kind_reg == KIND_DEBUG)
            begin
                if (frame_pos_reg < LINE_LIMIT && !line_held_reg)
                begin
                    result.write_target = TGT_LINE;
                    result.write_index  = line_len_reg;
                    if (item.rx_byte == SYM_LF)
                    begin
                        result.line_done = 1'b1;
                        line_held_next   = 1'b1;
                        line_len_next    = 8'd0;
                    end
                    else
                    begin
                        result.write_byte = (item.rx_byte == SYM_CR) ? 8'd0 : item.rx_byte;
                        line_len_next     = line_len_reg + 8'd1;
                    end
                end
            end
            else if (message_kind_reg == KIND_DATA)
            begin
                if (frame_pos_reg == 8'd2)
                begin
                    data_kind_next = item.rx_byte;
                end
                else if (kind_known && frame_pos_reg < REC_LIMIT)
                begin
                    result.write_target = TGT_DATA;
                    result.write_index  = frame_pos_reg;
                    result.write_byte   = item.rx_byte;
                    if (frame_pos_reg == LAST_POS)
                    begin
                        if (data_kind_reg == DK_ACCEL)
                        begin
                            result.record_done = REC_ACCEL;
                        end
                        else if (data_kind_reg == DK_GYRO)
                        begin
                            result.record_done = REC_GYRO;
                        end
                        else
                        begin
                            result.record_done = REC_ROT;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos_reg    <= 8'd0;
            message_kind_reg <= 8'd0;
            data_kind_reg    <= 8'd0;
            line_len_reg     <= 8'd0;
            line_held_reg    <= 1'b0;
        end
        else if (advance)
        begin
            frame_pos_reg    <= frame_pos_next;
            message_kind_reg <= message_kind_next;
            data_kind_reg    <= data_kind_next;
            line_len_reg     <= line_len_next;
            line_held_reg    <= line_held_next;
        end
    end

endmodule

// ===== src/sfp_out_stage.sv =====
module sfp_out_stage
    import sfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sfp_res_if.source res_ch,
    input  logic      load,
    input  sfp_res_t  result,
    output logic      can_load
);

    logic     valid_reg;
    sfp_res_t data_reg;

    // free when empty or when the waiting result leaves this cycle
    assign can_load = !valid_reg || res_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign res_ch.valid        = valid_reg;
    assign res_ch.write_target = data_reg.write_target;
    assign res_ch.write_index  = data_reg.write_index;
    assign res_ch.write_byte   = data_reg.write_byte;
    assign res_ch.record_done  = data_reg.record_done;
    assign res_ch.line_done    = data_reg.line_done;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import sfp_pkg::*;

    // record size of the block under test, same as its default
    localparam int REC_BYTES    = 16;
    // stimulus stops once this many requests have been accepted
    localparam int TARGET_ITEMS = 1550;
    // generous bound: every request may wait out a long gap and a long stall
    localparam int CYCLE_LIMIT  = 400000;
    // pipeline depth is two registers; wait a few more cycles at the end
    localparam int DRAIN_CYCLES = 8;

    localparam sfp_res_t NO_WRITE = '0;

    logic clk;
    logic rst_n;

    sfp_req_if req_ch ();
    sfp_res_if res_ch ();

    sensor_frame_parser_top #(
        .RECORD_BYTES (REC_BYTES)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .req_ch (req_ch),
        .res_ch (res_ch)
    );

    // one row of the directed table; fixed rows carry their expected result,
    // the other rows are checked against the frame predictor
    typedef struct packed {
        logic       fixed;
        logic       req_type;
        logic [7:0] rx_byte;
        sfp_res_t   res;
    } dir_row_t;

    localparam int DIR_ROWS = 26;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // release straight after reset: nothing held, all zero
        '{1'b1, REQ_RELEASE, 8'h00,      NO_WRITE},
        // a stray byte before any frame start is ignored
        '{1'b1, REQ_BYTE,    8'h00,      NO_WRITE},
        // debug frame: start and kind bytes never write
        '{1'b1, REQ_BYTE,    SYM_START,  NO_WRITE},
        '{1'b1, REQ_BYTE,    KIND_DEBUG, NO_WRITE},
        '{1'b0, REQ_BYTE,    8'h41,      NO_WRITE},
        // carriage return is stored as zero
        '{1'b0, REQ_BYTE,    SYM_CR,     NO_WRITE},
        // newline terminates and holds the line
        '{1'b0, REQ_BYTE,    SYM_LF,     NO_WRITE},
        // text while the line is held is dropped
        '{1'b0, REQ_BYTE,    8'h42,      NO_WRITE},
        '{1'b1, REQ_RELEASE, 8'hFF,      NO_WRITE},
        // accel data frame filled to the last record byte and one past it
        '{1'b1, REQ_BYTE,    SYM_START,  NO_WRITE},
        '{1'b1, REQ_BYTE,    KIND_DATA,  NO_WRITE},
        '{1'b1, REQ_BYTE,    DK_ACCEL,   NO_WRITE},
        '{1'b0, REQ_BYTE,    8'h00,      NO_WRITE},
        '{1'b0, REQ_BYTE,    8'hFF,      NO_WRITE},
        '{1'b0, REQ_BYTE,    8'h00,      NO_WRITE},
        '{1'b0, REQ_BYTE,    8'hFF,      NO_WRITE},
        '{1'b0, REQ_BYTE,    8'h00,      NO_WRITE},
        '{1'b0, REQ_BYTE,    8'hFF,      NO_WRITE},
        '{1'b0, REQ_BYTE,    8'h00,      NO_WRITE},
        '{1'b0, REQ_BYTE,    8'hFF,      NO_WRITE},
        '{1'b0, REQ_BYTE,    8'h00,      NO_WRITE},
        '{1'b0, REQ_BYTE,    8'hFF,      NO_WRITE},
        '{1'b0, REQ_BYTE,    8'h00,      NO_WRITE},
        '{1'b0, REQ_BYTE,    8'hFF,      NO_WRITE},
        '{1'b1, REQ_BYTE,    8'hA5,
          '{TGT_DATA, 8'd15, 8'hA5, REC_ACCEL, 1'b0}},
        // payload past the record size is dropped
        '{1'b1, REQ_BYTE,    8'h5A,      NO_WRITE}
    };

    // predictor state, mirrors the deframer registers
    logic [7:0] frame_pos_p = '0;
    logic [7:0] msg_kind_p  = '0;
    logic [7:0] data_kind_p = '0;
    logic [7:0] line_len_p  = '0;
    logic       held_p      = 1'b0;

    sfp_res_t expected_q [$];

    int  accepted_cnt = 0;
    int  checked_cnt  = 0;
    int  line_cnt     = 0;
    int  record_cnt   = 0;
    int  error_cnt    = 0;
    // when set, both sides run back to back with no idling
    bit  calm         = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // advance the frame predictor by one request and return its result
    function automatic sfp_res_t predict_frame(input sfp_req_t r);
        sfp_res_t res;
        res = '0;
        if (r.req_type == REQ_RELEASE)
        begin
            held_p = 1'b0;
        end
        else
        begin
            if (r.rx_byte == SYM_START)
            begin
                frame_pos_p = '0;
            end
            else if (frame_pos_p == 8'd1)
            begin
                msg_kind_p = r.rx_byte;
            end
            else if (msg_kind_p == KIND_DEBUG)
            begin
                if (frame_pos_p < REC_BYTES - 2 && !held_p)
                begin
                    res.write_target = TGT_LINE;
                    res.write_index  = line_len_p;
                    if (r.rx_byte == SYM_LF)
                    begin
                        res.line_done = 1'b1;
                        held_p        = 1'b1;
                        line_len_p    = '0;
                    end
                    else
                    begin
                        res.write_byte = (r.rx_byte == SYM_CR) ? 8'h00 : r.rx_byte;
                        line_len_p     = line_len_p + 8'd1;
                    end
                end
            end
            else if (msg_kind_p == KIND_DATA)
            begin
                if (frame_pos_p == 8'd2)
                begin
                    data_kind_p = r.rx_byte;
                end
                else if (data_kind_p == DK_ACCEL || data_kind_p == DK_GYRO ||
                         data_kind_p == DK_ROT)
                begin
                    if (frame_pos_p < REC_BYTES)
                    begin
                        res.write_target = TGT_DATA;
                        res.write_index  = frame_pos_p;
                        res.write_byte   = r.rx_byte;
                        if (frame_pos_p == REC_BYTES - 1)
                        begin
                            if (data_kind_p == DK_ACCEL)
                                res.record_done = REC_ACCEL;
                            else if (data_kind_p == DK_GYRO)
                                res.record_done = REC_GYRO;
                            else
                                res.record_done = REC_ROT;
                        end
                    end
                end
            end
            frame_pos_p = frame_pos_p + 8'd1;
        end
        return res;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_idle();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // random byte that only rarely restarts a frame
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == SYM_START && $urandom_range(0, 3) != 0)
            b = b ^ 8'h01;
        return b;
    endfunction

    // one request transfer; called and returning at a rising edge
    task automatic send_req(input sfp_req_t r, input logic fixed, input sfp_res_t fixed_res);
        int       gap;
        sfp_res_t pred;
        gap = pick_idle();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= r.req_type;
        req_ch.rx_byte  <= r.rx_byte;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // transfer taken at this edge
        pred = predict_frame(r);
        expected_q.push_back(fixed ? fixed_res : pred);
        accepted_cnt++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_req('{REQ_BYTE, b}, 1'b0, NO_WRITE);
    endtask

    task automatic send_release();
        send_req('{REQ_RELEASE, 8'($urandom_range(0, 255))}, 1'b0, NO_WRITE);
    endtask

    // debug frame with random text, carriage returns, newlines and releases
    task automatic debug_frame();
        int         n;
        int         r;
        logic [7:0] b;
        send_byte(SYM_START);
        send_byte(KIND_DEBUG);
        n = $urandom_range(0, 16);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                b = SYM_LF;
            else if (r < 14)
                b = SYM_CR;
            else
                b = body_byte();
            if ($urandom_range(0, 19) == 0)
                send_release();
            send_byte(b);
        end
        if (held_p && $urandom_range(0, 9) < 7)
            send_release();
    endtask

    // data frame, mostly a full record of a known kind
    task automatic data_frame();
        int         n;
        int         r;
        logic [7:0] kind;
        send_byte(SYM_START);
        send_byte(KIND_DATA);
        r = $urandom_range(0, 99);
        if (r < 30)
            kind = DK_ACCEL;
        else if (r < 58)
            kind = DK_GYRO;
        else if (r < 86)
            kind = DK_ROT;
        else
            kind = 8'($urandom_range(0, 255));
        send_byte(kind);
        if ($urandom_range(0, 99) < 60)
            n = REC_BYTES - 3;
        else
            n = $urandom_range(0, REC_BYTES + 2);
        for (int i = 0; i < n; i++)
            send_byte(body_byte());
    endtask

    // frame of an unknown message kind; its bytes are all dropped
    task automatic unknown_frame();
        logic [7:0] kind;
        int         n;
        kind = 8'($urandom_range(0, 255));
        if (kind == KIND_DATA || kind == KIND_DEBUG || kind == SYM_START)
            kind = 8'hC3;
        send_byte(SYM_START);
        send_byte(kind);
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++)
            send_byte(body_byte());
    endtask

    // many debug frames without newline, so the line length wraps
    task automatic long_line();
        logic [7:0] b;
        send_release();
        for (int f = 0; f < 22; f++)
        begin
            send_byte(SYM_START);
            send_byte(KIND_DEBUG);
            for (int i = 0; i < REC_BYTES - 4; i++)
            begin
                b = body_byte();
                if (b == SYM_LF || b == SYM_START)
                    b = 8'h61;
                send_byte(b);
            end
        end
    endtask

    // gyro frame long enough for the frame position to wrap
    task automatic wrap_frame();
        logic [7:0] b;
        send_byte(SYM_START);
        send_byte(KIND_DATA);
        send_byte(DK_GYRO);
        for (int i = 0; i < 262; i++)
        begin
            b = body_byte();
            if (b == SYM_START)
                b = 8'h00;
            send_byte(b);
        end
    endtask

    // result receiver: random stalls on ready
    initial
    begin
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = pick_idle();
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_cnt++;
        end
    endtask

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        sfp_res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result transfer with no expectation pending");
                error_cnt++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("write_target", want.write_target, res_ch.write_target);
                check_field("write_index",  want.write_index,  res_ch.write_index);
                check_field("write_byte",   want.write_byte,   res_ch.write_byte);
                check_field("record_done",  want.record_done,  res_ch.record_done);
                check_field("line_done",    want.line_done,    res_ch.line_done);
                checked_cnt++;
                if (res_ch.line_done)
                    line_cnt++;
                if (res_ch.record_done != REC_NONE)
                    record_cnt++;
            end
        end
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, expected_q.size());
        $display("** sensor_frame_parser_top: FAILED **");
        $finish;
    end

    // reset, directed table, then random frames
    initial
    begin
        int  pick;
        bit  did_long_line;
        bit  did_wrap;
        did_long_line = 1'b0;
        did_wrap      = 1'b0;
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_BYTE;
        req_ch.rx_byte  <= 8'h00;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_req('{DIRECTED[i].req_type, DIRECTED[i].rx_byte},
                     DIRECTED[i].fixed, DIRECTED[i].res);

        while (accepted_cnt < TARGET_ITEMS)
        begin
            if ($urandom_range(0, 19) == 0)
                calm = !calm;
            pick = $urandom_range(0, 99);
            if (!did_long_line && accepted_cnt > 300)
            begin
                long_line();
                did_long_line = 1'b1;
            end
            else if (!did_wrap && accepted_cnt > 800)
            begin
                wrap_frame();
                did_wrap = 1'b1;
            end
            else if (pick < 35)
                debug_frame();
            else if (pick < 75)
                data_frame();
            else if (pick < 82)
                send_release();
            else if (pick < 90)
                unknown_frame();
            else
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
        req_ch.valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d requests (directed table plus random frames), checked %0d results",
                 accepted_cnt, checked_cnt);
        $display("saw %0d finished debug lines and %0d completed data records",
                 line_cnt, record_cnt);
        if (error_cnt == 0 && expected_q.size() == 0)
            $display("** sensor_frame_parser_top: PASSED **");
        else
            $display("** sensor_frame_parser_top: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
src/sfp_pkg.sv
src/sfp_if.sv
src/sfp_in_stage.sv
src/sfp_deframer.sv
src/sfp_out_stage.sv
src/sensor_frame_parser_top.sv
tb/tb_top.sv
